FILE: rtl/gsfd_pkg.sv
// gsfd_pkg: shared types and constants of the gamepad serial frame decoder
// used by gsfd_ctrl and gamepad_serial_frame_decoder_top
`default_nettype none

package gsfd_pkg;

	localparam int unsigned FRAME_LEN = 10;
	localparam int unsigned CHAR_W    = 6;
	localparam int unsigned COUNT_W   = $clog2(FRAME_LEN + 1);

	localparam logic [7:0]        LINE_END   = 8'd10;
	localparam logic [CHAR_W-1:0] CHAR_BIAS  = 6'h20;
	localparam logic [7:0]        STICK_REST = 8'd127;

	typedef enum logic [1:0] {
		ST_GOOD = 2'd0,
		ST_LEN  = 2'd1,
		ST_SUM  = 2'd2
	} frame_status_t;

	typedef logic [CHAR_W-1:0] char_t;

	typedef struct packed {
		logic  shift;
		logic  full;
		logic  overlong;
		char_t sum;
	} frame_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/gsfd_cell.sv
// gsfd_cell: one character slot of the frame store chain
// plain register stage, no package dependency
`default_nettype none

module gsfd_cell #(
	parameter int unsigned WIDTH = 6
) (
	input  wire logic             clk,
	input  wire logic             shift,
	input  wire logic [WIDTH-1:0] char_in,
	output logic      [WIDTH-1:0] char_q
);

	always_ff @(posedge clk) begin
		if (shift) begin
			char_q <= char_in;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/gsfd_ctrl.sv
// gsfd_ctrl: character count, overlong flag and running checksum of a frame
// depends on gsfd_pkg
`default_nettype none

module gsfd_ctrl
	import gsfd_pkg::*;
(
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  accept,
	input  wire logic  is_lf,
	input  wire char_t char_in,
	output frame_ctrl_t ctrl
);

	logic [COUNT_W-1:0] count_q;
	logic               overlong_q;
	char_t              sum_q;
	logic               full;

	assign full = (count_q == COUNT_W'(FRAME_LEN));

	always_comb begin
		ctrl.shift    = accept && !is_lf && !full;
		ctrl.full     = full;
		ctrl.overlong = overlong_q;
		ctrl.sum      = sum_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			overlong_q <= 1'b0;
			sum_q      <= '0;
		end else if (accept) begin
			if (is_lf) begin
				count_q    <= '0;
				overlong_q <= 1'b0;
				sum_q      <= '0;
			end else if (full) begin
				overlong_q <= 1'b1;
			end else begin
				count_q <= count_q + COUNT_W'(1);
				// checksum covers the first nine characters only
				if (count_q < COUNT_W'(FRAME_LEN - 1)) begin
					sum_q <= sum_q + char_in;
				end
			end
		end
	end

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(FRAME_LEN))
		else $error("character count beyond frame length");

	a_overlong_full: assert property (@(posedge clk) disable iff (!arst_n)
		overlong_q |-> full)
		else $error("overlong flag without full frame");

	a_lf_clears: assert property (@(posedge clk) disable iff (!arst_n)
		accept && is_lf |=> count_q == '0 && !overlong_q && sum_q == '0)
		else $error("frame end did not clear the frame state");

endmodule

`default_nettype wire

FILE: rtl/gamepad_serial_frame_decoder_top.sv
// gamepad_serial_frame_decoder_top: serial frame decoder top level
// a frame end item gives its result item in the output register in the next cycle
// throughput: one item per cycle; input stalls only while an unread result is held
// characters move through a row of ten cells; checksum is summed as characters arrive
// reset (arst_n, asynchronous): count and flags cleared, buttons 0, sticks 127
// depends on gsfd_pkg, gsfd_cell, gsfd_ctrl
`default_nettype none

module gamepad_serial_frame_decoder_top
	import gsfd_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	input  wire logic [7:0]   s_tdata,   // rx_byte[7:0]
	output logic              m_tvalid,
	input  wire logic         m_tready,
	output logic      [103:0] m_tdata,   // buttons, left_x, left_y, right_x, right_y,
	                                     // buttons_changed, pressed_edges, released_edges, pad
	output logic      [1:0]   m_tuser    // frame_status
);

	logic        accept;
	logic        is_lf;
	char_t       char_in;
	frame_ctrl_t ctrl;
	char_t       cell_q [FRAME_LEN];

	logic [15:0] button_map_q;
	logic [7:0]  stick_q [4];

	frame_status_t status;
	logic [15:0]   now_buttons;
	logic [7:0]    now_stick [4];
	char_t         c [FRAME_LEN];

	logic          out_valid_q;
	frame_status_t out_status_q;
	logic [15:0]   out_buttons_q;
	logic [7:0]    out_stick_q [4];
	logic          out_changed_q;
	logic [15:0]   out_pressed_q;
	logic [15:0]   out_released_q;

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign is_lf    = (s_tdata == LINE_END);
	assign char_in  = s_tdata[CHAR_W-1:0] - CHAR_BIAS;

	gsfd_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.is_lf   (is_lf),
		.char_in (char_in),
		.ctrl    (ctrl)
	);

	for (genvar i = 0; i < FRAME_LEN; i++) begin : g_cell
		if (i == 0) begin : g_head
			gsfd_cell #(.WIDTH(CHAR_W)) u_cell (
				.clk     (clk),
				.shift   (ctrl.shift),
				.char_in (char_in),
				.char_q  (cell_q[i])
			);
		end else begin : g_body
			gsfd_cell #(.WIDTH(CHAR_W)) u_cell (
				.clk     (clk),
				.shift   (ctrl.shift),
				.char_in (cell_q[i-1]),
				.char_q  (cell_q[i])
			);
		end
		// oldest character sits at the far end of the chain
		assign c[i] = cell_q[FRAME_LEN-1-i];
	end

	always_comb begin
		if (ctrl.overlong || !ctrl.full) begin
			status = ST_LEN;
		end else if (ctrl.sum != c[9]) begin
			status = ST_SUM;
		end else begin
			status = ST_GOOD;
		end
	end

	always_comb begin
		now_buttons  = {c[2][3:0], c[1], c[0]};
		now_stick[0] = {c[4][1:0], c[3]};
		now_stick[1] = {c[5][3:0], c[4][5:2]};
		now_stick[2] = {c[6], c[5][5:4]};
		now_stick[3] = {c[8][1:0], c[7]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			button_map_q <= '0;
			for (int k = 0; k < 4; k++) begin
				stick_q[k] <= STICK_REST;
			end
		end else begin
			if (accept && is_lf) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (accept && is_lf && status == ST_GOOD) begin
				button_map_q <= now_buttons;
				for (int k = 0; k < 4; k++) begin
					stick_q[k] <= now_stick[k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_lf) begin
			out_status_q <= status;
			if (status == ST_GOOD) begin
				out_buttons_q  <= now_buttons;
				out_changed_q  <= (now_buttons != button_map_q);
				out_pressed_q  <= now_buttons & ~button_map_q;
				out_released_q <= button_map_q & ~now_buttons;
				for (int k = 0; k < 4; k++) begin
					out_stick_q[k] <= now_stick[k];
				end
			end else begin
				out_buttons_q  <= button_map_q;
				out_changed_q  <= 1'b0;
				out_pressed_q  <= '0;
				out_released_q <= '0;
				for (int k = 0; k < 4; k++) begin
					out_stick_q[k] <= stick_q[k];
				end
			end
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {23'd0, out_released_q, out_pressed_q, out_changed_q,
		out_stick_q[3], out_stick_q[2], out_stick_q[1], out_stick_q[0], out_buttons_q};

	a_bad_no_edges: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != ST_GOOD |->
			!out_changed_q && out_pressed_q == '0 && out_released_q == '0)
		else $error("bad frame reports button edges");

	a_edges_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_pressed_q & out_released_q) == '0)
		else $error("button both pressed and released");

	a_changed_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_changed_q == ((out_pressed_q | out_released_q) != '0))
		else $error("change flag disagrees with edges");

	a_map_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_buttons_q == button_map_q)
		else $error("reported buttons differ from stored map");

endmodule

`default_nettype wire
